// File: rtl/cspl_pkg.sv
// Shared types, constants and helper functions of the cubic spline evaluator.
`timescale 1ns / 1ps

package cspl_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_KNOTS_DEF = 64;
  localparam int FRAC_BITS_DEF = 16;

  // Knot count register
  localparam int          KC_W     = 7;
  localparam logic [6:0]  KC_RESET = 7'd2;

  // Saturation bounds of a 32-bit signed result
  localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
  localparam logic signed [63:0] S32_MIN = -64'sd2147483648;
  localparam logic signed [31:0] V32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] V32_MIN = 32'sh8000_0000;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_VALUE  = 2'd1,
    OP_FIRST  = 2'd2,
    OP_SECOND = 2'd3
  } opcode_t;

  typedef struct packed {
    opcode_t            opcode;
    logic [5:0]         knot_index;
    logic signed [31:0] knot_pos;
    logic signed [31:0] coef_const;
    logic signed [31:0] coef_lin;
    logic signed [31:0] coef_quad;
    logic signed [31:0] coef_cube;
    logic signed [31:0] query_t;
  } spl_in_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic [5:0]         segment;
    logic [1:0]         result_kind;
    logic               saturated;
  } spl_out_t;

  // One knot table entry
  typedef struct packed {
    logic signed [31:0] knot_pos;
    logic signed [31:0] coef_const;
    logic signed [31:0] coef_lin;
    logic signed [31:0] coef_quad;
    logic signed [31:0] coef_cube;
  } knot_entry_t;

  // Controller state
  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_LAST,
    S_CLAMP_HI,
    S_CLAMP_LO,
    S_SRCH_CHK,
    S_SRCH_CMP,
    S_DX,
    S_MUL,
    S_POST,
    S_FIN
  } state_t;

  // Multiplier operand pairs
  typedef enum logic [2:0] {
    MUL_DX_DX,
    MUL_DX2_DX,
    MUL_B_DX,
    MUL_C_DX2,
    MUL_D_DX3,
    MUL_C_DX,
    MUL_D_DX2,
    MUL_D_DX
  } mul_sel_t;

  // Where a truncated product goes
  typedef enum logic [1:0] {
    DST_DX2,
    DST_DX3,
    DST_ACC
  } dest_t;

  // Scale applied to a product before it is accumulated
  typedef enum logic [1:0] {
    SC_1,
    SC_2,
    SC_3,
    SC_6
  } scale_t;

  typedef struct packed {
    mul_sel_t mul_sel;
    dest_t    dest;
    scale_t   scale;
    logic     last;
  } step_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic     mem_we;
    logic     start;
    logic     rd_en;
    logic     clamp_hi;
    logic     clamp_lo;
    logic     dx_step;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     post_en;
    dest_t    dest;
    scale_t   scale;
    logic     out_load;
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic    gt;
    opcode_t op;
  } dp_stat_t;

  typedef struct packed {
    logic               clip;
    logic signed [31:0] val;
  } sat_t;

  // Clip a 64-bit signed value to 32 bits and flag the clip
  function automatic sat_t sat32(input logic signed [63:0] v);
    sat_t r;
    r.clip = 1'b0;
    r.val  = v[31:0];
    if (v > S32_MAX) begin
      r.clip = 1'b1;
      r.val  = V32_MAX;
    end else if (v < S32_MIN) begin
      r.clip = 1'b1;
      r.val  = V32_MIN;
    end
    return r;
  endfunction

  // Multiply sequence of each query kind
  function automatic step_t seq_step(input opcode_t op, input logic [2:0] idx);
    step_t s;
    s = '{mul_sel: MUL_D_DX, dest: DST_ACC, scale: SC_1, last: 1'b1};
    case (op)
      OP_VALUE: begin
        case (idx)
          3'd0: s = '{mul_sel: MUL_DX_DX,  dest: DST_DX2, scale: SC_1, last: 1'b0};
          3'd1: s = '{mul_sel: MUL_DX2_DX, dest: DST_DX3, scale: SC_1, last: 1'b0};
          3'd2: s = '{mul_sel: MUL_B_DX,   dest: DST_ACC, scale: SC_1, last: 1'b0};
          3'd3: s = '{mul_sel: MUL_C_DX2,  dest: DST_ACC, scale: SC_1, last: 1'b0};
          3'd4: s = '{mul_sel: MUL_D_DX3,  dest: DST_ACC, scale: SC_1, last: 1'b1};
          default: s = '{mul_sel: MUL_D_DX3, dest: DST_ACC, scale: SC_1, last: 1'b1};
        endcase
      end
      OP_FIRST: begin
        case (idx)
          3'd0: s = '{mul_sel: MUL_DX_DX, dest: DST_DX2, scale: SC_1, last: 1'b0};
          3'd1: s = '{mul_sel: MUL_C_DX,  dest: DST_ACC, scale: SC_2, last: 1'b0};
          3'd2: s = '{mul_sel: MUL_D_DX2, dest: DST_ACC, scale: SC_3, last: 1'b1};
          default: s = '{mul_sel: MUL_D_DX2, dest: DST_ACC, scale: SC_3, last: 1'b1};
        endcase
      end
      OP_SECOND: s = '{mul_sel: MUL_D_DX, dest: DST_ACC, scale: SC_6, last: 1'b1};
      default:   s = '{mul_sel: MUL_D_DX, dest: DST_ACC, scale: SC_1, last: 1'b1};
    endcase
    return s;
  endfunction

endpackage

// File: rtl/cspl_dp.sv
// Datapath of the spline evaluator: knot memory, clamp, compare, multiplier, accumulator.
`timescale 1ns / 1ps

module cspl_dp
  import cspl_pkg::*;
#(
  parameter int MAX_KNOTS = MAX_KNOTS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  localparam int AW = $clog2(MAX_KNOTS)
) (
  input  logic          clk,
  input  spl_in_t       in_item,
  input  dp_cmd_t       cmd,
  input  logic [AW-1:0] rd_addr,
  output dp_stat_t      status,
  output spl_out_t      out_item
);

  knot_entry_t        mem_r [MAX_KNOTS];
  knot_entry_t        rd_r;
  knot_entry_t        wr_entry;
  logic               idx_ok;
  logic [AW-1:0]      wr_addr;

  logic signed [31:0] t_r;
  opcode_t            op_r;
  logic [5:0]         seg_r;
  logic               sat_r;
  logic signed [31:0] dx_r;
  logic signed [31:0] dx2_r;
  logic signed [31:0] dx3_r;
  logic signed [63:0] prod_r;
  logic signed [63:0] acc_r;
  spl_out_t           out_r;

  logic signed [31:0] op_a;
  logic signed [31:0] op_b;
  logic signed [63:0] diff;
  logic signed [63:0] q;
  logic signed [63:0] q_scaled;
  logic signed [63:0] acc_seed;
  sat_t               dx_sat;
  sat_t               q_sat;
  sat_t               fin_sat;

  // Write one knot entry; drop indexes beyond the table
  assign wr_entry = '{knot_pos:   in_item.knot_pos,
                      coef_const: in_item.coef_const,
                      coef_lin:   in_item.coef_lin,
                      coef_quad:  in_item.coef_quad,
                      coef_cube:  in_item.coef_cube};
  assign idx_ok  = (32'(in_item.knot_index) < MAX_KNOTS);
  assign wr_addr = AW'(in_item.knot_index);

  always_ff @(posedge clk) begin
    if (cmd.mem_we && idx_ok) begin
      mem_r[wr_addr] <= wr_entry;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_r <= mem_r[rd_addr];
    end
  end

  // Search compare against the entry just read
  assign status.gt = (t_r > rd_r.knot_pos);
  assign status.op = op_r;

  // Offset into the chosen segment
  assign diff   = 64'(t_r) - 64'(rd_r.knot_pos);
  assign dx_sat = sat32(diff);

  // Select multiplier operands
  always_comb begin
    case (cmd.mul_sel)
      MUL_DX_DX:  begin op_a = dx_r;              op_b = dx_r;  end
      MUL_DX2_DX: begin op_a = dx2_r;             op_b = dx_r;  end
      MUL_B_DX:   begin op_a = rd_r.coef_lin;     op_b = dx_r;  end
      MUL_C_DX2:  begin op_a = rd_r.coef_quad;    op_b = dx2_r; end
      MUL_D_DX3:  begin op_a = rd_r.coef_cube;    op_b = dx3_r; end
      MUL_C_DX:   begin op_a = rd_r.coef_quad;    op_b = dx_r;  end
      MUL_D_DX2:  begin op_a = rd_r.coef_cube;    op_b = dx2_r; end
      MUL_D_DX:   begin op_a = rd_r.coef_cube;    op_b = dx_r;  end
      default:    begin op_a = dx_r;              op_b = dx_r;  end
    endcase
  end

  // Truncate the product toward minus infinity and scale it
  assign q     = prod_r >>> FRAC_BITS;
  assign q_sat = sat32(q);

  always_comb begin
    case (cmd.scale)
      SC_1:    q_scaled = q;
      SC_2:    q_scaled = q <<< 1;
      SC_3:    q_scaled = q + (q <<< 1);
      SC_6:    q_scaled = (q <<< 1) + (q <<< 2);
      default: q_scaled = q;
    endcase
  end

  // Starting term of the sum for each query kind
  always_comb begin
    case (op_r)
      OP_VALUE:  acc_seed = 64'(rd_r.coef_const);
      OP_FIRST:  acc_seed = 64'(rd_r.coef_lin);
      OP_SECOND: acc_seed = 64'(rd_r.coef_quad) <<< 1;
      default:   acc_seed = 64'(rd_r.coef_const);
    endcase
  end

  assign fin_sat = sat32(acc_r);

  // Query registers
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      t_r   <= in_item.query_t;
      op_r  <= in_item.opcode;
      sat_r <= 1'b0;
    end else if (cmd.clamp_hi) begin
      if (t_r > rd_r.knot_pos) begin
        t_r <= rd_r.knot_pos;
      end
    end else if (cmd.clamp_lo) begin
      if (t_r < rd_r.knot_pos) begin
        t_r <= rd_r.knot_pos;
      end
    end else if (cmd.dx_step) begin
      dx_r  <= dx_sat.val;
      sat_r <= sat_r | dx_sat.clip;
      seg_r <= 6'(rd_addr);
      acc_r <= acc_seed;
    end else if (cmd.post_en) begin
      case (cmd.dest)
        DST_DX2: begin
          dx2_r <= q_sat.val;
          sat_r <= sat_r | q_sat.clip;
        end
        DST_DX3: begin
          dx3_r <= q_sat.val;
          sat_r <= sat_r | q_sat.clip;
        end
        DST_ACC: acc_r <= acc_r + q_scaled;
        default: acc_r <= acc_r;
      endcase
    end
  end

  // Product register
  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r <= op_a * op_b;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r.result_value <= fin_sat.val;
      out_r.segment      <= seg_r;
      out_r.result_kind  <= op_r;
      out_r.saturated    <= sat_r | fin_sat.clip;
    end
  end

  assign out_item = out_r;

endmodule

// File: rtl/cspl_ctrl.sv
// Controller of the spline evaluator: handshakes, knot count, search indexes, step sequence.
`timescale 1ns / 1ps

module cspl_ctrl
  import cspl_pkg::*;
#(
  parameter int MAX_KNOTS = MAX_KNOTS_DEF,
  localparam int AW = $clog2(MAX_KNOTS)
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  opcode_t         in_opcode,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  logic            cfg_we,
  input  logic [KC_W-1:0] cfg_wdata,
  input  dp_stat_t        status,
  output dp_cmd_t         cmd,
  output logic [AW-1:0]   rd_addr
);

  localparam int KW = (AW + 1 > KC_W) ? AW + 1 : KC_W;

  state_t            state_r, state_nxt;
  logic [KC_W-1:0]   knot_count_r;
  logic [AW-1:0]     lo_r, lo_nxt;
  logic [AW-1:0]     hi_r, hi_nxt;
  logic [AW-1:0]     mid_r, mid_nxt;
  logic [2:0]        step_r, step_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic [KW-1:0]     kc_ext;
  logic [KW-1:0]     n_eff;
  logic [AW-1:0]     nlast;
  logic [AW:0]       mid_sum;
  logic [AW-1:0]     mid;
  logic [AW-1:0]     span;
  logic              accept;
  logic              out_free;
  step_t             step;

  // Knot count clipped to the table
  always_comb begin
    kc_ext = KW'(knot_count_r);
    if (kc_ext < KW'(2)) begin
      n_eff = KW'(2);
    end else if (kc_ext > KW'(MAX_KNOTS)) begin
      n_eff = KW'(MAX_KNOTS);
    end else begin
      n_eff = kc_ext;
    end
  end
  assign nlast = AW'(n_eff - KW'(1));

  // Midpoint and width of the search interval
  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid     = mid_sum[AW:1];
  assign span    = hi_r - lo_r;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign step      = seq_step(status.op, step_r);

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    step_nxt      = step_r;
    cmd           = '0;
    cmd.mul_sel   = step.mul_sel;
    cmd.dest      = step.dest;
    cmd.scale     = step.scale;
    rd_addr       = lo_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_opcode == OP_LOAD) begin
            cmd.mem_we = 1'b1;
          end else begin
            cmd.start = 1'b1;
            state_nxt = S_RD_LAST;
          end
        end
      end
      S_RD_LAST: begin
        cmd.rd_en = 1'b1;
        rd_addr   = nlast;
        state_nxt = S_CLAMP_HI;
      end
      S_CLAMP_HI: begin
        cmd.clamp_hi = 1'b1;
        cmd.rd_en    = 1'b1;
        rd_addr      = '0;
        state_nxt    = S_CLAMP_LO;
      end
      S_CLAMP_LO: begin
        cmd.clamp_lo = 1'b1;
        lo_nxt       = '0;
        hi_nxt       = nlast;
        state_nxt    = S_SRCH_CHK;
      end
      S_SRCH_CHK: begin
        cmd.rd_en = 1'b1;
        if (span > AW'(1)) begin
          rd_addr   = mid;
          mid_nxt   = mid;
          state_nxt = S_SRCH_CMP;
        end else begin
          rd_addr   = lo_r;
          state_nxt = S_DX;
        end
      end
      S_SRCH_CMP: begin
        if (status.gt) begin
          lo_nxt = mid_r;
        end else begin
          hi_nxt = mid_r;
        end
        state_nxt = S_SRCH_CHK;
      end
      S_DX: begin
        cmd.dx_step = 1'b1;
        rd_addr     = lo_r;
        step_nxt    = '0;
        state_nxt   = S_MUL;
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = S_POST;
      end
      S_POST: begin
        cmd.post_en = 1'b1;
        if (step.last) begin
          state_nxt = S_FIN;
        end else begin
          step_nxt  = step_r + 3'd1;
          state_nxt = S_MUL;
        end
      end
      S_FIN: begin
        if (out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      knot_count_r <= KC_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        knot_count_r <= cfg_wdata;
      end
    end
  end

  // Search indexes and step counter
  always_ff @(posedge clk) begin
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    mid_r  <= mid_nxt;
    step_r <= step_nxt;
  end

  // The search interval never collapses
  a_span_open: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SRCH_CHK) |-> (lo_r < hi_r))
    else $error("search interval collapsed");

  // The step counter stays inside the longest sequence
  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL) |-> (step_r < 3'd5))
    else $error("step counter out of range");

  // An accepted query starts the table walk
  a_query_start: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_opcode != OP_LOAD)) |=> (state_r == S_RD_LAST))
    else $error("query did not start");

  // A finished query lands in the output register and frees the input
  a_fin_deliver: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_FIN) && out_free) |=> ((state_r == S_IDLE) && out_valid_r))
    else $error("finished item not delivered");

endmodule

// File: rtl/cubic_spline_segment_eval.sv
// Top level of the piecewise cubic spline evaluator.
`timescale 1ns / 1ps

// Load items (opcode 0) write one knot entry and return no result.
// A query clamps t to the first and last knot, binary searches the knot table for its
// segment and returns the value, first or second derivative in Q16.16 with saturation.
// The search depth grows with the clipped knot count n, and the number of multiplies
// is 5 for the value, 3 for the first derivative and 1 for the second: each search step
// costs one read of the knot memory plus one compare, and all products go through one
// shared 32x32 multiplier followed by a register. Once the result register loads,
// the block returns to idle and can take the next item. The next item is taken while a
// result waits to be read.

module cubic_spline_segment_eval
  import cspl_pkg::*;
#(
  parameter int MAX_KNOTS = MAX_KNOTS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  spl_in_t         in_item,
  output logic            out_valid,
  input  logic            out_stall,
  output spl_out_t        out_item,
  input  logic            cfg_we,
  input  logic [KC_W-1:0] cfg_wdata
);

  localparam int AW = $clog2(MAX_KNOTS);

  dp_cmd_t       cmd;
  dp_stat_t      status;
  logic [AW-1:0] rd_addr;

  // Sequencer
  cspl_ctrl #(
    .MAX_KNOTS (MAX_KNOTS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_item.opcode),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .status    (status),
    .cmd       (cmd),
    .rd_addr   (rd_addr)
  );

  // Table and arithmetic
  cspl_dp #(
    .MAX_KNOTS (MAX_KNOTS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk      (clk),
    .in_item  (in_item),
    .cmd      (cmd),
    .rd_addr  (rd_addr),
    .status   (status),
    .out_item (out_item)
  );

endmodule

// File: tb/spline_result_checker.sv
// Checker for the cubic spline evaluator: predicts each query result and compares it.
`timescale 1ns / 1ps

module spline_result_checker
  import cspl_pkg::*;
#(
  parameter int MAX_KNOTS = MAX_KNOTS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_stall,
  input  spl_in_t         in_item,
  input  logic            out_valid,
  input  logic            out_stall,
  input  spl_out_t        out_item,
  input  logic            cfg_we,
  input  logic [KC_W-1:0] cfg_wdata,
  input  logic            run_done,
  output int              err_count,
  output int              pending
);

  localparam longint LIM_HI = 64'sd2147483647;
  localparam longint LIM_LO = -64'sd2147483648;

  // Local copy of the knot table and the knot count register
  logic signed [31:0] x_tab [MAX_KNOTS];
  logic signed [31:0] a_tab [MAX_KNOTS];
  logic signed [31:0] b_tab [MAX_KNOTS];
  logic signed [31:0] c_tab [MAX_KNOTS];
  logic signed [31:0] d_tab [MAX_KNOTS];
  logic [KC_W-1:0]    knots_reg;

  spl_out_t expected_results[$];
  bit       leftover_checked;

  initial begin
    err_count        = 0;
    pending          = 0;
    leftover_checked = 1'b0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH at %0t ns: %s got 0x%0h expected 0x%0h", $time, what, got, want);
    err_count++;
  endtask

  function automatic longint sx(input logic signed [31:0] v);
    return v;
  endfunction

  // Clip to the 32-bit signed range and note the clip
  function automatic longint clip32(input longint v, inout bit hit);
    if (v > LIM_HI) begin
      hit = 1'b1;
      return LIM_HI;
    end
    if (v < LIM_LO) begin
      hit = 1'b1;
      return LIM_LO;
    end
    return v;
  endfunction

  // Fixed-point product, floor of the dropped fraction bits
  function automatic longint qmul(input longint p, input longint q);
    return (p * q) >>> FRAC_BITS;
  endfunction

  // Clamp t, search the segment and evaluate the requested derivative
  function automatic spl_out_t spline_eval(input spl_in_t q);
    int       n, lo, hi, mid;
    longint   t, dx, dx2, dx3, acc;
    bit       hit;
    spl_out_t r;
    hit = 1'b0;
    n = int'(knots_reg);
    if (n < 2) n = 2;
    if (n > MAX_KNOTS) n = MAX_KNOTS;
    t = sx(q.query_t);
    if (t > sx(x_tab[n-1])) t = sx(x_tab[n-1]);
    if (t < sx(x_tab[0])) t = sx(x_tab[0]);
    lo = 0;
    hi = n - 1;
    while (hi - lo > 1) begin
      mid = (lo + hi) / 2;
      if (t > sx(x_tab[mid])) lo = mid;
      else hi = mid;
    end
    dx = clip32(t - sx(x_tab[lo]), hit);
    case (q.opcode)
      OP_VALUE: begin
        dx2 = clip32(qmul(dx, dx), hit);
        dx3 = clip32(qmul(dx2, dx), hit);
        acc = sx(a_tab[lo]) + qmul(sx(b_tab[lo]), dx) + qmul(sx(c_tab[lo]), dx2)
            + qmul(sx(d_tab[lo]), dx3);
      end
      OP_FIRST: begin
        dx2 = clip32(qmul(dx, dx), hit);
        acc = sx(b_tab[lo]) + 2 * qmul(sx(c_tab[lo]), dx) + 3 * qmul(sx(d_tab[lo]), dx2);
      end
      default: begin
        acc = 2 * sx(c_tab[lo]) + 6 * qmul(sx(d_tab[lo]), dx);
      end
    endcase
    acc = clip32(acc, hit);
    r.result_value = acc[31:0];
    r.segment      = lo[5:0];
    r.result_kind  = q.opcode;
    r.saturated    = hit;
    return r;
  endfunction

  // Watch both channels and the register port
  always @(posedge clk) begin
    spl_out_t want;
    if (!rst_n) begin
      knots_reg = KC_RESET;
      expected_results.delete();
    end else begin
      // compare a delivered result with the oldest expectation
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing expected", out_item.result_value, '0);
        end else begin
          want = expected_results.pop_front();
          if (out_item.result_value !== want.result_value)
            report_mismatch("result_value", out_item.result_value, want.result_value);
          if (out_item.segment !== want.segment)
            report_mismatch("segment", 32'(out_item.segment), 32'(want.segment));
          if (out_item.result_kind !== want.result_kind)
            report_mismatch("result_kind", 32'(out_item.result_kind), 32'(want.result_kind));
          if (out_item.saturated !== want.saturated)
            report_mismatch("saturated", 32'(out_item.saturated), 32'(want.saturated));
        end
      end
      if (cfg_we) knots_reg = cfg_wdata;
      // store a load, predict a query
      if (in_valid && !in_stall) begin
        if (in_item.opcode == OP_LOAD) begin
          if (int'(in_item.knot_index) < MAX_KNOTS) begin
            x_tab[in_item.knot_index] = in_item.knot_pos;
            a_tab[in_item.knot_index] = in_item.coef_const;
            b_tab[in_item.knot_index] = in_item.coef_lin;
            c_tab[in_item.knot_index] = in_item.coef_quad;
            d_tab[in_item.knot_index] = in_item.coef_cube;
          end
        end else begin
          expected_results = {expected_results, spline_eval(in_item)};
        end
      end
      // flag expectations that never got a result
      if (run_done && !leftover_checked) begin
        leftover_checked = 1'b1;
        if (expected_results.size() != 0)
          report_mismatch("results never delivered", '0, 32'(expected_results.size()));
      end
    end
    pending = expected_results.size();
  end

endmodule

// File: tb/tb_cubic_spline_segment_eval.sv
// Top of the cubic spline evaluator testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_cubic_spline_segment_eval;
  import cspl_pkg::*;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_valid;
  logic            in_stall;
  spl_in_t         in_item;
  logic            out_valid;
  logic            out_stall;
  spl_out_t        out_item;
  logic            cfg_we;
  logic [KC_W-1:0] cfg_wdata;
  logic            run_done;
  int              err_count;
  int              pending;

  // Stimulus bookkeeping
  logic signed [31:0] knot_x [64];
  int                 n_used;
  int                 items_sent;
  int                 tx_idle_pct;
  int                 rx_idle_pct;
  bit                 hold_req;
  bit                 coef_full;

  always #6 clk = ~clk;

  cubic_spline_segment_eval DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  spline_result_checker u_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .run_done  (run_done),
    .err_count (err_count),
    .pending   (pending)
  );

  // Offer one item after an optional idle burst, hold it until accepted
  task automatic send_item(input spl_in_t it);
    int gap;
    gap = 0;
    if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct)
      gap = $urandom_range(1, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic load_knot(input int idx, input logic signed [31:0] pos,
                           input logic signed [31:0] a, input logic signed [31:0] b,
                           input logic signed [31:0] c, input logic signed [31:0] d);
    spl_in_t it;
    it.opcode     = OP_LOAD;
    it.knot_index = idx[5:0];
    it.knot_pos   = pos;
    it.coef_const = a;
    it.coef_lin   = b;
    it.coef_quad  = c;
    it.coef_cube  = d;
    it.query_t    = $urandom;
    knot_x[idx]   = pos;
    send_item(it);
  endtask

  // Query with random noise in the fields it does not use
  task automatic send_query(input opcode_t op, input logic signed [31:0] t);
    spl_in_t it;
    it.opcode     = op;
    it.knot_index = 6'($urandom);
    it.knot_pos   = $urandom;
    it.coef_const = $urandom;
    it.coef_lin   = $urandom;
    it.coef_quad  = $urandom;
    it.coef_cube  = $urandom;
    it.query_t    = t;
    send_item(it);
  endtask

  // Drop valid, wait for every expected result, then let the block settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    for (int w = 0; pending != 0 && w < 20000; w++) @(negedge clk);
    repeat (64) @(negedge clk);
  endtask

  task automatic write_knot_count(input int v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v[KC_W-1:0];
    @(negedge clk);
    cfg_we    <= 1'b0;
    n_used = (v < 2) ? 2 : (v > 64) ? 64 : v;
  endtask

  function automatic logic signed [31:0] rand_coef();
    if (coef_full) return $urandom;
    return $signed($urandom_range(0, 1 << 21)) - (1 << 20);
  endfunction

  // Load entries 0 to n-1 with a fresh table of the given shape
  task automatic fill_table(input int shape);
    logic signed [31:0] new_x [64];
    longint             p, step, maxstep;
    bit                 descend;
    maxstep = (shape == 0) ? (64'sd1 << $urandom_range(4, 18))
                           : (64'sd1 << $urandom_range(18, 24));
    p = -(longint'(n_used) * maxstep) / 2 + longint'($urandom_range(0, 1 << 20))
        - (1 << 19);
    for (int i = 0; i < n_used; i++) begin
      if (shape == 2) begin
        new_x[i] = $urandom;
      end else begin
        step = $urandom_range(1, int'(maxstep));
        // repeat a position now and then
        if (shape == 3 && $urandom_range(0, 3) == 0) step = 0;
        if (i > 0) p = p + step;
        if (p > 64'sd2147483647) p = 64'sd2147483647;
        new_x[i] = p[31:0];
      end
    end
    descend = $urandom_range(0, 1);
    for (int i = 0; i < n_used; i++) begin
      int k;
      k = descend ? n_used - 1 - i : i;
      load_knot(k, new_x[k], rand_coef(), rand_coef(), rand_coef(), rand_coef());
    end
  endtask

  // Pick an evaluation point: inside, on a knot, next to one, outside, or anywhere
  function automatic logic signed [31:0] pick_t();
    longint lo, hi;
    int     sel, r;
    sel = $urandom_range(0, 99);
    r   = $urandom_range(0, n_used - 1);
    lo  = knot_x[0];
    hi  = knot_x[n_used-1];
    if (sel < 45) begin
      if (hi > lo) return 32'(lo + longint'($urandom) % (hi - lo + 1));
      return knot_x[0];
    end
    if (sel < 60) return knot_x[r];
    if (sel < 70) return $urandom_range(0, 1) ? knot_x[r] + 1 : knot_x[r] - 1;
    if (sel < 80) return $urandom;
    if (sel < 85) return 32'sh8000_0000;
    if (sel < 90) return 32'sh7FFF_FFFF;
    if (sel < 95) return knot_x[0] - 1 - $urandom_range(0, 65535);
    return knot_x[n_used-1] + 1 + $urandom_range(0, 65535);
  endfunction

  // Result side: random stall bursts, and one long hold on request
  initial begin
    out_stall = 1'b0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (300) @(negedge clk);
        hold_req = 1'b0;
      end else if (rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 15)) @(negedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 20)) @(negedge clk);
      end
    end
  end

  // Hard stop for a hung run
  initial begin
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int kc_list [8];
    int phase, target, kc, nq;
    logic signed [31:0] q16;
    kc_list     = '{64, 0, 127, 1, 2, 65, 7, 33};
    in_valid    = 1'b0;
    in_item     = '0;
    cfg_we      = 1'b0;
    cfg_wdata   = KC_RESET;
    run_done    = 1'b0;
    hold_req    = 1'b0;
    coef_full   = 1'b1;
    tx_idle_pct = 20;
    rx_idle_pct = 20;
    items_sent  = 0;
    n_used      = 2;
    q16         = 32'sh0001_0000;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Extreme knots at reset count: away from the first knot a huge dx saturates
    load_knot(0, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    load_knot(1, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    send_query(OP_VALUE, 32'sh7FFF_FFFF);
    send_query(OP_FIRST, 32'sh7FFF_FFFF);
    send_query(OP_SECOND, 32'sh7FFF_FFFF);
    send_query(OP_VALUE, 32'sh8000_0000);
    send_query(OP_FIRST, 32'sh0000_0000);
    send_query(OP_SECOND, 32'sh8000_0000);
    send_query(OP_VALUE, 32'sh0000_0000);
    // Positions out of order: the clamp pins t to the first knot
    load_knot(0, 5 * q16, q16, -q16, 2 * q16, q16 / 4);
    load_knot(1, q16, -q16, q16, q16, -q16);
    send_query(OP_VALUE, 3 * q16);
    send_query(OP_FIRST, 0);
    // Ordinary segment: on the first knot, inside, on the last, below, above
    load_knot(0, 0, q16, -2 * q16, 3 * q16, q16 / 4);
    load_knot(1, 4 * q16, 2 * q16, q16, -q16, q16 / 2);
    send_query(OP_VALUE, 0);
    send_query(OP_VALUE, 2 * q16);
    send_query(OP_FIRST, 2 * q16);
    send_query(OP_SECOND, 2 * q16);
    send_query(OP_VALUE, 4 * q16);
    send_query(OP_FIRST, -1);
    send_query(OP_SECOND, 10 * q16);
    wait_idle();

    // Random phases, each with its own knot count and table
    target = items_sent + 1200;
    phase  = 0;
    while (items_sent < target) begin
      if (target - items_sent < 250) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end else begin
        tx_idle_pct = 25 * $urandom_range(0, 2);
        rx_idle_pct = 25 * $urandom_range(0, 2);
      end
      kc = (phase < 8) ? kc_list[phase] : $urandom_range(0, 127);
      write_knot_count(kc);
      coef_full = ($urandom_range(0, 2) == 0);
      fill_table($urandom_range(0, 3));
      // fill the block while results are held back
      if (phase == 2) hold_req = 1'b1;
      nq = $urandom_range(30, 80);
      for (int i = 0; i < nq; i++) begin
        if ($urandom_range(0, 19) == 0)
          load_knot($urandom_range(0, 63), $urandom, $urandom, $urandom, $urandom, $urandom);
        else
          send_query(opcode_t'($urandom_range(1, 3)), pick_t());
      end
      wait_idle();
      phase++;
    end

    run_done <= 1'b1;
    @(negedge clk);
    @(negedge clk);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/cspl_pkg.sv
rtl/cspl_dp.sv
rtl/cspl_ctrl.sv
rtl/cubic_spline_segment_eval.sv
tb/spline_result_checker.sv
tb/tb_cubic_spline_segment_eval.sv
